>>> rtl/cma_pkg.sv
// Shared constants, types and helper functions of the covariance matrix accumulator.
package cma_pkg;

   // Sizes of the vector and of the lower-triangle store
   localparam int DIM_MAX   = 64;
   localparam int DIM_AW    = $clog2(DIM_MAX);
   localparam int DIM_W     = $clog2(DIM_MAX + 1);
   localparam int TRI_DEPTH = (DIM_MAX * (DIM_MAX + 1)) / 2;
   localparam int TRI_AW    = $clog2(TRI_DEPTH);

   // Field widths
   localparam int KIND_W    = 2;
   localparam int SAMPLE_W  = 16;
   localparam int IDX_W     = 6;
   localparam int ENTRY_W   = 32;
   localparam int STATUS_W  = 2;
   localparam int DIM_REG_W = 7;
   localparam int PROD_W    = 2 * SAMPLE_W;
   localparam int SUM_W     = 48;
   localparam int COUNT_W   = 16;

   localparam logic [DIM_REG_W-1:0] DIM_RESET = DIM_REG_W'(DIM_MAX);
   localparam logic [COUNT_W-1:0]   COUNT_MAX = '1;

   typedef enum logic [KIND_W-1:0] {
      KIND_ELEM  = 2'd0,
      KIND_READ  = 2'd1,
      KIND_CLEAR = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_RANGE = 2'd2,
      ST_DROP  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_ELEM_START,
      S_ELEM_RUN,
      S_ELEM_DRAIN,
      S_READ_ADDR,
      S_READ_WAIT,
      S_DIV,
      S_RESP
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic       load_item;
      logic       elem_start;
      logic       elem_issue;
      logic       read_issue;
      logic       div_start;
      logic       clear;
      logic       rsp_load;
      status_type rsp_status;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      kind_type kind;
      logic     count_full;
      logic     count_zero;
      logic     out_of_range;
      logic     last_issue;
      logic     pipe_busy;
      logic     div_done;
      logic     rsp_free;
   } stat_type;

   // Address of the first entry of a row in the lower triangle: r*(r+1)/2
   function automatic logic [TRI_AW-1:0] tri_row_base(input logic [DIM_AW-1:0] r);
      logic [DIM_AW:0]   r1;
      logic [2*DIM_AW+1:0] prod;
      r1   = (DIM_AW + 1)'(r) + (DIM_AW + 1)'(1);
      prod = (2 * DIM_AW + 2)'(r) * (2 * DIM_AW + 2)'(r1);
      return TRI_AW'(prod >> 1);
   endfunction

endpackage

>>> rtl/cma_if.sv
// Handshake interfaces of the request, response and register-write channels.
interface cma_req_if;
   import cma_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [KIND_W-1:0]          kind;
   logic signed [SAMPLE_W-1:0] sample;
   logic [IDX_W-1:0]           row;
   logic [IDX_W-1:0]           col;
   modport source (output valid, kind, sample, row, col, input ready);
   modport sink (input valid, kind, sample, row, col, output ready);
endinterface

interface cma_rsp_if;
   import cma_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [ENTRY_W-1:0] entry;
   logic [STATUS_W-1:0]       status;
   modport source (output valid, entry, status, input ready);
   modport sink (input valid, entry, status, output ready);
endinterface

interface cma_csr_if;
   import cma_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [DIM_REG_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

>>> rtl/cma_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cma_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/cma_div.sv
// Serial restoring divider: signed sum over unsigned vector count, saturated to 32 bits.
module cma_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [cma_pkg::SUM_W-1:0]   dividend,
   input  logic [cma_pkg::COUNT_W-1:0]        divisor,
   output logic                         done,
   output logic signed [cma_pkg::ENTRY_W-1:0] quotient
);
   import cma_pkg::*;

   localparam int CNT_W = $clog2(SUM_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                neg_ff, neg_in;
   logic [SUM_W-1:0]    acc_ff, acc_in;
   logic [COUNT_W-1:0]  rem_ff, rem_in;
   logic [COUNT_W-1:0]  div_ff, div_in;
   logic [COUNT_W:0]    rem_shift;
   logic [COUNT_W:0]    rem_diff;
   logic                q_bit;

   // One quotient bit per cycle: shift the next dividend bit into the remainder
   always_comb begin
      rem_shift = {rem_ff, acc_ff[SUM_W-1]};
      rem_diff  = rem_shift - {1'b0, div_ff};
      q_bit     = (rem_shift >= {1'b0, div_ff});

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(SUM_W - 1);
         neg_in  = dividend[SUM_W-1];
         acc_in  = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = q_bit ? rem_diff[COUNT_W-1:0] : rem_shift[COUNT_W-1:0];
         acc_in = {acc_ff[SUM_W-2:0], q_bit};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state is reset; the arithmetic registers are not
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   // Apply the sign and saturate the magnitude to the 32-bit range
   always_comb begin
      if (neg_ff) begin
         if ((|acc_ff[SUM_W-1:ENTRY_W]) || (acc_ff[ENTRY_W-1] && (|acc_ff[ENTRY_W-2:0]))) begin
            quotient = {1'b1, {(ENTRY_W - 1){1'b0}}};
         end else begin
            quotient = $signed(-acc_ff[ENTRY_W-1:0]);
         end
      end else begin
         if (|acc_ff[SUM_W-1:ENTRY_W-1]) begin
            quotient = {1'b0, {(ENTRY_W - 1){1'b1}}};
         end else begin
            quotient = $signed(acc_ff[ENTRY_W-1:0]);
         end
      end
   end

   assign done = done_ff;
endmodule

>>> rtl/cma_ctrl.sv
// Controller state machine that sequences element updates, reads and clears.
module cma_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  cma_pkg::stat_type  stat,
   output cma_pkg::cmd_type   cmd
);
   import cma_pkg::*;

   state_type  state_ff, state_in;
   status_type status_ff, status_in;

   // State register; the pending status needs no reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      status_ff <= status_in;
   end

   // Next state and commands
   always_comb begin
      state_in       = state_ff;
      status_in      = status_ff;
      cmd            = '0;
      cmd.rsp_status = status_ff;
      req_ready      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.kind)
               KIND_ELEM: begin
                  if (stat.count_full) begin
                     status_in = ST_DROP;
                     state_in  = S_RESP;
                  end else begin
                     state_in = S_ELEM_START;
                  end
               end
               KIND_READ: begin
                  // The range check comes before the empty check
                  if (stat.out_of_range) begin
                     status_in = ST_RANGE;
                     state_in  = S_RESP;
                  end else if (stat.count_zero) begin
                     status_in = ST_EMPTY;
                     state_in  = S_RESP;
                  end else begin
                     state_in = S_READ_ADDR;
                  end
               end
               KIND_CLEAR: begin
                  cmd.clear = 1'b1;
                  state_in  = S_IDLE;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_ELEM_START: begin
            cmd.elem_start = 1'b1;
            state_in       = S_ELEM_RUN;
         end
         S_ELEM_RUN: begin
            cmd.elem_issue = 1'b1;
            if (stat.last_issue) begin
               state_in = S_ELEM_DRAIN;
            end
         end
         S_ELEM_DRAIN: begin
            if (!stat.pipe_busy) begin
               state_in = S_IDLE;
            end
         end
         S_READ_ADDR: begin
            cmd.read_issue = 1'b1;
            state_in       = S_READ_WAIT;
         end
         S_READ_WAIT: begin
            cmd.div_start = 1'b1;
            status_in     = ST_OK;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (stat.div_done) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end
endmodule

>>> rtl/cma_datapath.sv
// Datapath: item registers, counters, vector buffer, triangle store, update pipeline and divider.
module cma_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  cma_pkg::cmd_type                    cmd,
   output cma_pkg::stat_type                   stat,
   input  logic [cma_pkg::KIND_W-1:0]          req_kind,
   input  logic signed [cma_pkg::SAMPLE_W-1:0] req_sample,
   input  logic [cma_pkg::IDX_W-1:0]           req_row,
   input  logic [cma_pkg::IDX_W-1:0]           req_col,
   input  logic                                csr_valid,
   input  logic [cma_pkg::DIM_REG_W-1:0]       csr_data,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic signed [cma_pkg::ENTRY_W-1:0]  rsp_entry,
   output logic [cma_pkg::STATUS_W-1:0]        rsp_status
);
   import cma_pkg::*;

   // Latched item
   kind_type                   kind_ff;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic [IDX_W-1:0]           row_ff;
   logic [IDX_W-1:0]           col_ff;

   // Configuration and counters
   logic [DIM_REG_W-1:0] dimension_ff, dimension_in;
   logic [DIM_W-1:0]     eff_dim;
   logic [DIM_AW-1:0]    elem_idx_ff, elem_idx_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [DIM_MAX-1:0]   row_valid_ff, row_valid_in;

   // Row update pass
   logic [DIM_AW-1:0]    cur_i;
   logic [DIM_W-1:0]     next_pos;
   logic [DIM_AW-1:0]    row_i_ff;
   logic [DIM_AW-1:0]    j_ff;
   logic [TRI_AW-1:0]    row_base_ff;
   logic                 row_fresh_ff;
   logic                 p2_valid_ff, p3_valid_ff;
   logic [TRI_AW-1:0]    p2_addr_ff, p3_addr_ff;
   logic signed [PROD_W-1:0] product_ff;
   logic signed [SUM_W-1:0]  acc_ff;

   // Read path
   logic [IDX_W-1:0]     hi, lo;
   logic [TRI_AW-1:0]    read_addr;
   logic [TRI_AW-1:0]    elem_addr;
   logic                 read_valid_ff;

   // Memory and divider connections
   logic [SAMPLE_W-1:0]  buf_q;
   logic [SUM_W-1:0]     tri_q;
   logic [SUM_W-1:0]     tri_wdata;
   logic [TRI_AW-1:0]    tri_rd_addr;
   logic signed [SUM_W-1:0]   div_dividend;
   logic signed [ENTRY_W-1:0] div_quotient;
   logic                      div_done;

   // Response register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [ENTRY_W-1:0] rsp_entry_ff;
   logic [STATUS_W-1:0]       rsp_status_ff;

   // Effective dimension: the register clamped to one through the maximum
   always_comb begin
      if (dimension_ff == '0) begin
         eff_dim = DIM_W'(1);
      end else if (DIM_W'(dimension_ff) > DIM_W'(DIM_MAX)) begin
         eff_dim = DIM_W'(DIM_MAX);
      end else begin
         eff_dim = DIM_W'(dimension_ff);
      end
   end

   // A stale index after a dimension change starts a new vector
   assign cur_i    = (DIM_W'(elem_idx_ff) >= eff_dim) ? '0 : elem_idx_ff;
   assign next_pos = DIM_W'(cur_i) + DIM_W'(1);

   // Mirror the requested entry into the lower triangle
   assign hi        = (row_ff > col_ff) ? row_ff : col_ff;
   assign lo        = (row_ff > col_ff) ? col_ff : row_ff;
   assign read_addr = tri_row_base(hi[DIM_AW-1:0]) + TRI_AW'(lo);
   assign elem_addr = row_base_ff + TRI_AW'(j_ff);

   // Control registers: configuration, element index, vector count, row valid bits
   always_comb begin
      dimension_in = dimension_ff;
      elem_idx_in  = elem_idx_ff;
      count_in     = count_ff;
      row_valid_in = row_valid_ff;

      if (csr_valid) begin
         dimension_in = csr_data;
      end
      if (cmd.elem_start) begin
         row_valid_in[cur_i] = 1'b1;
         if (next_pos >= eff_dim) begin
            elem_idx_in = '0;
            count_in    = count_ff + COUNT_W'(1);
         end else begin
            elem_idx_in = DIM_AW'(next_pos);
         end
      end
      if (cmd.clear) begin
         elem_idx_in  = '0;
         count_in     = '0;
         row_valid_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dimension_ff <= DIM_RESET;
         elem_idx_ff  <= '0;
         count_ff     <= '0;
         row_valid_ff <= '0;
      end else begin
         dimension_ff <= dimension_in;
         elem_idx_ff  <= elem_idx_in;
         count_ff     <= count_in;
         row_valid_ff <= row_valid_in;
      end
   end

   // Item capture and row pass set-up
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         kind_ff   <= kind_type'(req_kind);
         sample_ff <= req_sample;
         row_ff    <= req_row;
         col_ff    <= req_col;
      end
      if (cmd.elem_start) begin
         row_i_ff     <= cur_i;
         row_base_ff  <= tri_row_base(cur_i);
         row_fresh_ff <= !row_valid_ff[cur_i];
         j_ff         <= '0;
      end else if (cmd.elem_issue) begin
         j_ff <= j_ff + DIM_AW'(1);
      end
      if (cmd.read_issue) begin
         read_valid_ff <= row_valid_ff[hi[DIM_AW-1:0]];
      end
   end

   // Update pipeline: read, multiply, write back
   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
      end else begin
         p2_valid_ff <= cmd.elem_issue;
         p3_valid_ff <= p2_valid_ff;
      end
      p2_addr_ff <= elem_addr;
      p3_addr_ff <= p2_addr_ff;
      product_ff <= PROD_W'(sample_ff) * PROD_W'($signed(buf_q));
      acc_ff     <= row_fresh_ff ? '0 : $signed(tri_q);
   end

   assign tri_wdata   = SUM_W'(acc_ff + SUM_W'(product_ff));
   assign tri_rd_addr = cmd.read_issue ? read_addr : elem_addr;

   // Current vector's elements
   cma_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (DIM_MAX)
   ) u_vec_ram (
      .clock   (clock),
      .wr_en   (cmd.elem_start),
      .wr_addr (cur_i),
      .wr_data (sample_ff),
      .rd_en   (cmd.elem_issue),
      .rd_addr (j_ff),
      .rd_data (buf_q)
   );

   // Lower-triangle sums
   cma_ram #(
      .WIDTH (SUM_W),
      .DEPTH (TRI_DEPTH)
   ) u_tri_ram (
      .clock   (clock),
      .wr_en   (p3_valid_ff),
      .wr_addr (p3_addr_ff),
      .wr_data (tri_wdata),
      .rd_en   (cmd.elem_issue || cmd.read_issue),
      .rd_addr (tri_rd_addr),
      .rd_data (tri_q)
   );

   // A row never written since the last clear reads as zero
   assign div_dividend = read_valid_ff ? $signed(tri_q) : '0;

   cma_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_entry_ff  <= (cmd.rsp_status == ST_OK) ? div_quotient : '0;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_entry  = rsp_entry_ff;
   assign rsp_status = rsp_status_ff;

   // Status towards the controller
   assign stat.kind         = kind_ff;
   assign stat.count_full   = (count_ff == COUNT_MAX);
   assign stat.count_zero   = (count_ff == '0);
   assign stat.out_of_range = (DIM_W'(row_ff) >= eff_dim) || (DIM_W'(col_ff) >= eff_dim);
   assign stat.last_issue   = (j_ff == row_i_ff);
   assign stat.pipe_busy    = p2_valid_ff || p3_valid_ff;
   assign stat.div_done     = div_done;
   assign stat.rsp_free     = !rsp_valid_ff || rsp_ready;
endmodule

>>> rtl/covariance_matrix_accumulator_core.sv
// Top level of the covariance matrix accumulator: controller, datapath and channel wiring.
//
//   Channel  Direction  Carries
//   req_ch   in         kind, sample, row, col
//   rsp_ch   out        entry, status
//   csr_ch   in         dimension (always ready)
//
// An element item i sends row i of the triangle through a read, multiply and
// write-back pipeline on the triangle RAM, one entry per cycle.
// A read item waits on the 48-step serial divider; a clear or an unused kind ends in
// the decode state, and an out-of-range or empty read or a dropped element goes to the response.
// Reset and clear act at once through per-row valid bits; there is no clearing pass.
// A finished result waits in the output register while the next item is accepted.
module covariance_matrix_accumulator_core (
   input logic        clock,
   input logic        reset,
   cma_req_if.sink    req_ch,
   cma_rsp_if.source  rsp_ch,
   cma_csr_if.sink    csr_ch
);
   import cma_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // Register writes are taken in any cycle
   assign csr_ch.ready = 1'b1;

   cma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   cma_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_kind   (req_ch.kind),
      .req_sample (req_ch.sample),
      .req_row    (req_ch.row),
      .req_col    (req_ch.col),
      .csr_valid  (csr_ch.valid),
      .csr_data   (csr_ch.data),
      .rsp_ready  (rsp_ch.ready),
      .rsp_valid  (rsp_ch.valid),
      .rsp_entry  (rsp_ch.entry),
      .rsp_status (rsp_ch.status)
   );
endmodule

>>> tb/sv/tb_covariance_matrix_accumulator_core.sv
// Self-checking testbench for the covariance matrix accumulator core.
module tb_covariance_matrix_accumulator_core;
   import cma_pkg::*;

   localparam int IDLE_LIMIT    = 5000;
   localparam int SETTLE_CYCLES = 100;
   localparam int HOLD_CYCLES   = 400;
   localparam int RANDOM_ITEMS  = 1600;
   localparam int PRINT_LIMIT   = 100;

   // Tracks the accumulator state and holds the entries the block should return.
   class cov_checker;
      typedef struct {
         logic signed [ENTRY_W-1:0] entry;
         status_type                status;
      } entry_result_type;

      logic [DIM_REG_W-1:0]       dim_reg;
      logic signed [SAMPLE_W-1:0] vec_buf [DIM_MAX];
      logic signed [SUM_W-1:0]    tri_sum [TRI_DEPTH];
      int unsigned                elem_idx;
      int unsigned                vec_count;
      entry_result_type           expected_entries [$];
      int unsigned                mismatches;
      int unsigned                n_elems, n_reads, n_clears, n_drops, n_sat, n_dim_writes;

      function new();
         dim_reg = DIM_RESET;
         foreach (vec_buf[k]) vec_buf[k] = '0;
         wipe();
         mismatches   = 0;
         n_elems      = 0;
         n_reads      = 0;
         n_clears     = 0;
         n_drops      = 0;
         n_sat        = 0;
         n_dim_writes = 0;
      endfunction

      // The register is clamped to the range the store supports.
      function int unsigned dim_used();
         if (dim_reg == 0) return 1;
         if (dim_reg > DIM_MAX) return DIM_MAX;
         return dim_reg;
      endfunction

      function void wipe();
         foreach (tri_sum[k]) tri_sum[k] = '0;
         elem_idx  = 0;
         vec_count = 0;
      endfunction

      function int unsigned tri_addr(int unsigned r, int unsigned c);
         return (r * (r + 1)) / 2 + c;
      endfunction

      function void write_dimension(logic [DIM_REG_W-1:0] value);
         dim_reg = value;
         n_dim_writes++;
      endfunction

      function void expect_entry(logic signed [ENTRY_W-1:0] e, status_type s);
         entry_result_type x;
         x.entry  = e;
         x.status = s;
         expected_entries.push_back(x);
      endfunction

      // Applies one accepted item to the tracked state.
      function void note_request(kind_type kind, logic signed [SAMPLE_W-1:0] sample,
                                 logic [IDX_W-1:0] row, logic [IDX_W-1:0] col);
         int unsigned d, i, j, hi, lo;
         longint      prod, q;
         d = dim_used();
         case (kind)
            KIND_ELEM: begin
               if (vec_count >= COUNT_MAX) begin
                  // A full vector count drops the element.
                  n_drops++;
                  expect_entry('0, ST_DROP);
               end else begin
                  n_elems++;
                  // An index left over from a larger dimension restarts the vector.
                  if (elem_idx >= d) elem_idx = 0;
                  i = elem_idx;
                  vec_buf[i] = sample;
                  for (j = 0; j <= i; j++) begin
                     prod = longint'(sample) * longint'(vec_buf[j]);
                     tri_sum[tri_addr(i, j)] = tri_sum[tri_addr(i, j)] + SUM_W'(prod);
                  end
                  if (i + 1 >= d) begin
                     elem_idx = 0;
                     vec_count++;
                  end else begin
                     elem_idx = i + 1;
                  end
               end
            end
            KIND_READ: begin
               n_reads++;
               if (row >= d || col >= d) begin
                  expect_entry('0, ST_RANGE);
               end else if (vec_count == 0) begin
                  expect_entry('0, ST_EMPTY);
               end else begin
                  hi = (row > col) ? row : col;
                  lo = (row > col) ? col : row;
                  q  = longint'(tri_sum[tri_addr(hi, lo)]) / longint'(vec_count);
                  if (q > 64'sd2147483647) begin
                     q = 64'sd2147483647;
                     n_sat++;
                  end else if (q < -64'sd2147483648) begin
                     q = -64'sd2147483648;
                     n_sat++;
                  end
                  expect_entry(ENTRY_W'(q), ST_OK);
               end
            end
            KIND_CLEAR: begin
               n_clears++;
               wipe();
            end
            default: begin
            end
         endcase
      endfunction

      task report(string what);
         if (mismatches < PRINT_LIMIT) $display("MISMATCH at %0t: %s", $time, what);
         mismatches++;
      endtask

      // Compares one accepted response with the oldest expectation.
      task check_response(logic signed [ENTRY_W-1:0] entry, logic [STATUS_W-1:0] status);
         entry_result_type want;
         if (expected_entries.size() == 0) begin
            report($sformatf("response entry %0d status %0d with nothing expected",
                             entry, status));
         end else begin
            want = expected_entries.pop_front();
            if (status !== want.status)
               report($sformatf("status %0d, expected %0d", status, want.status));
            if (entry !== want.entry)
               report($sformatf("entry %0d, expected %0d", entry, want.entry));
         end
      endtask

      task finish_check();
         if (expected_entries.size() != 0)
            report($sformatf("%0d responses never arrived", expected_entries.size()));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   cma_req_if req_ch ();
   cma_rsp_if rsp_ch ();
   cma_csr_if csr_ch ();

   covariance_matrix_accumulator_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   cov_checker  tracker = new();
   bit          req_idle_on = 1'b0;
   bit          rsp_idle_on = 1'b0;
   int unsigned rsp_hold_cycles = 0;
   int unsigned items_sent = 0;

   wire any_accept = (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                     (csr_ch.valid && csr_ch.ready);

   // Clock with a period of 10.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Observe every handshake; responses first, since they belong to earlier items.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) tracker.check_response(rsp_ch.entry, rsp_ch.status);
         if (csr_ch.valid && csr_ch.ready) tracker.write_dimension(csr_ch.data);
         if (req_ch.valid && req_ch.ready)
            tracker.note_request(kind_type'(req_ch.kind), req_ch.sample, req_ch.row,
                                 req_ch.col);
      end
   end

   // Response side: random or no stalls, plus an occasional long hold-off.
   initial begin : rsp_sink
      int unsigned gap;
      rsp_ch.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         gap = rsp_idle_on ? $urandom_range(0, 6) : 0;
         if (rsp_hold_cycles != 0) begin
            gap = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         if (gap != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_ch.valid && rsp_ch.ready)) @(posedge clock);
      end
   end

   // Ends the run when nothing has moved for too long.
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if (any_accept) quiet = 0;
         else quiet++;
      end
      $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
      $display("FAILED: results differ");
      $finish;
   end

   // Offers one item, after a random gap when idling is on.
   task automatic send_item(kind_type kind, logic signed [SAMPLE_W-1:0] sample,
                            logic [IDX_W-1:0] row, logic [IDX_W-1:0] col);
      int unsigned gap;
      gap = req_idle_on ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.kind   <= kind;
      req_ch.sample <= sample;
      req_ch.row    <= row;
      req_ch.col    <= col;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_elem(logic signed [SAMPLE_W-1:0] sample);
      send_item(KIND_ELEM, sample, IDX_W'($urandom), IDX_W'($urandom));
   endtask

   task automatic send_read(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col);
      send_item(KIND_READ, SAMPLE_W'($urandom), row, col);
   endtask

   task automatic send_clear();
      send_item(KIND_CLEAR, SAMPLE_W'($urandom), IDX_W'($urandom), IDX_W'($urandom));
   endtask

   // Waits until every response is in and the last element has been worked off.
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (tracker.expected_entries.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_dim(logic [DIM_REG_W-1:0] value);
      settle();
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // Extremes turn up often; otherwise any 16-bit pattern.
   function automatic logic signed [SAMPLE_W-1:0] draw_sample();
      case ($urandom_range(0, 9))
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         2:       return '0;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // Mostly in range, sometimes any index.
   function automatic logic [IDX_W-1:0] draw_index(int unsigned d);
      if ($urandom_range(0, 9) == 0) return IDX_W'($urandom);
      return IDX_W'($urandom_range(0, d - 1));
   endfunction

   // Stimulus
   initial begin : stimulus
      logic [DIM_REG_W-1:0] preset [16];
      logic [DIM_REG_W-1:0] dim_pick;
      int unsigned          d, phase, random_base, phase_end, pick;

      preset = '{7'd1, 7'd0, 7'd127, 7'd64, 7'd2, 7'd3, 7'd65, 7'd7,
                 7'd16, 7'd5, 7'd100, 7'd33, 7'd64, 7'd4, 7'd12, 7'd1};

      req_ch.valid  <= 1'b0;
      req_ch.kind   <= KIND_NONE;
      req_ch.sample <= '0;
      req_ch.row    <= '0;
      req_ch.col    <= '0;
      csr_ch.valid  <= 1'b0;
      csr_ch.data   <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty reads, unused kind, partial vector, stale index,
      // out-of-range reads, saturated quotients and a clear.
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      send_read(6'd0, 6'd0);
      send_read(6'd63, 6'd63);
      send_item(KIND_NONE, 16'sh7FFF, 6'd63, 6'd63);
      send_elem(16'sh8000);
      send_elem(16'sh7FFF);
      send_read(6'd1, 6'd0);
      write_dim(7'd2);
      send_elem(16'sh8000);
      send_elem(16'sh7FFF);
      send_read(6'd2, 6'd0);
      send_read(6'd0, 6'd63);
      send_read(6'd1, 6'd0);
      send_read(6'd0, 6'd1);
      send_read(6'd0, 6'd0);
      write_dim(7'd64);
      send_elem(16'sh8000);
      send_elem(16'sh7FFF);
      send_read(6'd1, 6'd0);
      send_read(6'd0, 6'd0);
      send_read(6'd1, 6'd1);
      send_read(6'd63, 6'd0);
      send_elem('0);
      send_elem(-16'sd1);
      send_clear();
      send_read(6'd0, 6'd0);

      // Random phases, each with its own dimension and idling mix.
      random_base = items_sent;
      phase = 0;
      while (items_sent - random_base < RANDOM_ITEMS) begin
         dim_pick = (phase < 16) ? preset[phase] : DIM_REG_W'($urandom_range(0, 127));
         write_dim(dim_pick);
         d = (dim_pick == 0) ? 1 : (dim_pick > DIM_MAX) ? DIM_MAX : dim_pick;
         req_idle_on = ($urandom_range(0, 2) != 0);
         rsp_idle_on = ($urandom_range(0, 2) != 0);
         if ($urandom_range(0, 3) == 0) send_clear();

         // Hold the response side off while reads keep coming, so the input stalls.
         if (phase == 2 || phase == 9) begin
            rsp_hold_cycles = HOLD_CYCLES;
            req_idle_on = 1'b0;
            repeat (12) send_read(draw_index(d), draw_index(d));
         end

         phase_end = items_sent + 60 + $urandom_range(0, 80);
         while (items_sent < phase_end) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               repeat (d) send_elem(draw_sample());
            end else if (pick < 88) begin
               repeat ($urandom_range(1, 4)) send_read(draw_index(d), draw_index(d));
            end else if (pick < 92) begin
               send_clear();
            end else if (pick < 95) begin
               send_item(KIND_NONE, SAMPLE_W'($urandom), IDX_W'($urandom), IDX_W'($urandom));
            end else begin
               // Broken vector: only a part of it arrives.
               repeat ($urandom_range(1, d)) send_elem(draw_sample());
            end
         end
         phase++;
      end

      // Close with one-element vectors, reads on and past the edge, and a clear.
      write_dim(7'd1);
      send_clear();
      send_elem(16'sh7FFF);
      send_elem(16'sh8000);
      send_elem('0);
      send_read(6'd0, 6'd0);
      send_read(6'd1, 6'd0);
      send_clear();
      send_elem(16'sd5);
      send_read(6'd0, 6'd0);

      settle();
      tracker.finish_check();
      $display("Run covered %0d elements, %0d reads, %0d clears over %0d dimension writes.",
               tracker.n_elems, tracker.n_reads, tracker.n_clears, tracker.n_dim_writes);
      $display("Quotients saturated %0d times; %0d elements dropped at the count ceiling.",
               tracker.n_sat, tracker.n_drops);
      if (tracker.mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches", tracker.mismatches);
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
